// ===== rtl/sqlim_pkg.sv =====
// -----------------------------------------------------------------------------
// SQL injection matcher package
// Shared constants, pattern table, push bundle type and byte helper functions.
// -----------------------------------------------------------------------------
package sqlim_pkg;

  localparam int unsigned WINDOW_LEN_DEF = 18;
  localparam int unsigned PATTERN_COUNT  = 16;
  localparam int unsigned MAX_PAT_LEN    = 18;
  localparam int unsigned PUSH_MAX       = 3;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Bytes entering one window in a single cycle, oldest in data[0].
  typedef struct packed {
    logic [1:0]                 count;
    logic [PUSH_MAX-1:0][7:0]   data;
  } push_t;

  // Patterns are right-aligned: the final character sits in bits [7:0].
  localparam logic [MAX_PAT_LEN*8-1:0] PATTERNS [PATTERN_COUNT] = '{
    (MAX_PAT_LEN*8)'("' or "),
    (MAX_PAT_LEN*8)'("' and "),
    (MAX_PAT_LEN*8)'("\" or "),
    (MAX_PAT_LEN*8)'("\" and "),
    (MAX_PAT_LEN*8)'("union select"),
    (MAX_PAT_LEN*8)'("union all select"),
    (MAX_PAT_LEN*8)'("or 1=1"),
    (MAX_PAT_LEN*8)'("or '1'='1"),
    (MAX_PAT_LEN*8)'("drop table"),
    (MAX_PAT_LEN*8)'("drop database"),
    (MAX_PAT_LEN*8)'("; insert"),
    (MAX_PAT_LEN*8)'("; update"),
    (MAX_PAT_LEN*8)'("exec("),
    (MAX_PAT_LEN*8)'("execute("),
    (MAX_PAT_LEN*8)'({"xp_", "cmdshell"}),
    (MAX_PAT_LEN*8)'({"information", "_schema"})
  };

  localparam int unsigned PAT_LEN [PATTERN_COUNT] = '{
    5, 6, 5, 6, 12, 16, 6, 9, 10, 13, 8, 8, 5, 8, 11, 18
  };

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [3:0] r;
    r = c[3:0];
    if (c >= 8'h41) begin
      r = c[3:0] + 4'd9;
    end
    return r;
  endfunction

  function automatic logic [7:0] plus_map(input logic [7:0] c);
    return (c == CHAR_PLUS) ? CHAR_SPACE : c;
  endfunction

endpackage

// ===== rtl/sqlim_decoder.sv =====
// -----------------------------------------------------------------------------
// Percent decoder
// Turns one input byte into zero to three decoded bytes and flushes held
// bytes when the final byte of a string arrives.
// -----------------------------------------------------------------------------
module sqlim_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output sqlim_pkg::push_t  push_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [7:0] pend_q, pend_d;

  always_comb begin
    sqlim_pkg::push_t p;
    logic [1:0]       nc;
    logic [7:0]       p1n;
    p       = '0;
    nc      = cnt_q;
    p1n     = pend_q;
    unique case (cnt_q)
      2'd0: begin
        if (byte_i == sqlim_pkg::CHAR_PERCENT) begin
          nc = 2'd1;
        end else begin
          p.data[0] = sqlim_pkg::plus_map(byte_i);
          p.count   = 2'd1;
        end
      end
      2'd1: begin
        p1n = byte_i;
        nc  = 2'd2;
      end
      2'd2: begin
        if (sqlim_pkg::is_hex(pend_q) && sqlim_pkg::is_hex(byte_i)) begin
          p.data[0] = {sqlim_pkg::hex_nib(pend_q), sqlim_pkg::hex_nib(byte_i)};
          p.count   = 2'd1;
          nc        = 2'd0;
        end else begin
          // An invalid escape emits the percent sign and feeds both held
          // bytes through the decoder once more.
          p.data[0] = sqlim_pkg::CHAR_PERCENT;
          p.count   = 2'd1;
          nc        = 2'd0;
          if (pend_q == sqlim_pkg::CHAR_PERCENT) begin
            p1n = byte_i;
            nc  = 2'd2;
          end else begin
            p.data[1] = sqlim_pkg::plus_map(pend_q);
            p.count   = 2'd2;
            if (byte_i == sqlim_pkg::CHAR_PERCENT) begin
              nc = 2'd1;
            end else begin
              p.data[2] = sqlim_pkg::plus_map(byte_i);
              p.count   = 2'd3;
            end
          end
        end
      end
      default: begin
        nc = 2'd0;
      end
    endcase
    if (last_i) begin
      if (nc != 2'd0) begin
        p.data[p.count] = sqlim_pkg::CHAR_PERCENT;
        p.count         = p.count + 2'd1;
      end
      if (nc == 2'd2) begin
        p.data[p.count] = sqlim_pkg::plus_map(p1n);
        p.count         = p.count + 2'd1;
      end
      nc = 2'd0;
    end
    push_o = p;
    cnt_d  = en_i ? nc : cnt_q;
    pend_d = en_i ? p1n : pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      pend_q <= 8'd0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ===== rtl/sqlim_cell.sv =====
// -----------------------------------------------------------------------------
// Window cell
// Holds one byte of a window and takes the byte one to three places ahead.
// -----------------------------------------------------------------------------
module sqlim_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  clr_i,
  input  logic [1:0]                            shift_i,
  input  logic [sqlim_pkg::PUSH_MAX-1:0][7:0]   ahead_i,
  output logic [7:0]                            data_o
);

  logic [7:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (clr_i) begin
      data_d = 8'd0;
    end else if (en_i) begin
      unique case (shift_i)
        2'd0:    data_d = data_q;
        2'd1:    data_d = ahead_i[0];
        2'd2:    data_d = ahead_i[1];
        default: data_d = ahead_i[2];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= 8'd0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/sqlim_window.sv =====
// -----------------------------------------------------------------------------
// Match window
// A row of byte cells with the pattern comparators, checked after every
// byte that enters in a cycle.
// -----------------------------------------------------------------------------
module sqlim_window #(
  parameter int unsigned WINDOW_LEN = sqlim_pkg::WINDOW_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              clr_i,
  input  sqlim_pkg::push_t  push_i,
  output logic              hit_o
);

  localparam int unsigned ExtLen = WINDOW_LEN + sqlim_pkg::PUSH_MAX;

  logic [7:0] ext [ExtLen];
  logic [sqlim_pkg::PATTERN_COUNT-1:0][sqlim_pkg::PUSH_MAX-1:0] match;
  logic [sqlim_pkg::PUSH_MAX-1:0] end_ok;

  for (genvar j = 0; j < sqlim_pkg::PUSH_MAX; j++) begin : g_new
    assign ext[WINDOW_LEN+j] = sqlim_pkg::fold(push_i.data[j]);
    assign end_ok[j]         = (32'(push_i.count) > j);
  end

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    logic [sqlim_pkg::PUSH_MAX-1:0][7:0] ahead;
    for (genvar s = 0; s < sqlim_pkg::PUSH_MAX; s++) begin : g_ahead
      assign ahead[s] = ext[i+s+1];
    end
    sqlim_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .clr_i   (clr_i),
      .shift_i (push_i.count),
      .ahead_i (ahead),
      .data_o  (ext[i])
    );
  end

  // A pattern matches when it is a suffix of the stream ending at a new byte.
  for (genvar p = 0; p < sqlim_pkg::PATTERN_COUNT; p++) begin : g_pat
    for (genvar e = 0; e < sqlim_pkg::PUSH_MAX; e++) begin : g_end
      logic [sqlim_pkg::MAX_PAT_LEN-1:0] eq;
      for (genvar k = 0; k < sqlim_pkg::MAX_PAT_LEN; k++) begin : g_chr
        if (k < sqlim_pkg::PAT_LEN[p]) begin : g_use
          assign eq[k] = (ext[WINDOW_LEN+e-k] == sqlim_pkg::PATTERNS[p][8*k +: 8]);
        end else begin : g_pad
          assign eq[k] = 1'b1;
        end
      end
      assign match[p][e] = &eq & end_ok[e];
    end
  end

  assign hit_o = en_i & (|match);

endmodule

// ===== rtl/sql_injection_matcher_core.sv =====
// -----------------------------------------------------------------------------
// The result of a string appears in the cycle after its last byte. Throughput:
// one byte per cycle unless a result stalls; the decoded window shifts by up to
// three bytes a cycle and all comparators check every new byte in parallel.
// Reset: asynchronous, active low; windows, decoder and hit flag clear, and
// the same state clears again after every last byte.
// -----------------------------------------------------------------------------
// SQL injection matcher
// Scans raw and percent-decoded byte streams for fixed injection patterns.
// -----------------------------------------------------------------------------
module sql_injection_matcher_core #(
  parameter int unsigned WINDOW_LEN = sqlim_pkg::WINDOW_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       injection_found_o
);

  logic             accept;
  logic             clr;
  logic             raw_hit, dec_hit, hit_now;
  logic             hit_q, hit_d;
  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  sqlim_pkg::push_t raw_push, dec_push;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign clr        = accept & last_byte_i;

  always_comb begin
    raw_push         = '0;
    raw_push.count   = 2'd1;
    raw_push.data[0] = text_byte_i;
  end

  sqlim_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .byte_i (text_byte_i),
    .last_i (last_byte_i),
    .push_o (dec_push)
  );

  sqlim_window #(.WINDOW_LEN(WINDOW_LEN)) u_raw_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .clr_i  (clr),
    .push_i (raw_push),
    .hit_o  (raw_hit)
  );

  sqlim_window #(.WINDOW_LEN(WINDOW_LEN)) u_dec_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .clr_i  (clr),
    .push_i (dec_push),
    .hit_o  (dec_hit)
  );

  assign hit_now = raw_hit | dec_hit;

  always_comb begin
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (clr) begin
      out_valid_d = 1'b1;
      found_d     = hit_q | hit_now;
      hit_d       = 1'b0;
    end else if (accept) begin
      hit_d = hit_q | hit_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign injection_found_o = found_q;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> out_valid_o)
    else $error("no result after the last byte of a string");

  a_plain_byte_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !last_byte_i && (!out_valid_o || out_ready_i)) |=> !out_valid_o)
    else $error("result raised without a last byte");

  a_hit_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> !hit_q)
    else $error("hit flag survived the end of a string");

endmodule
